// ===== rtl/gpl_pkg.sv =====
// gpl_pkg: opcodes, register indexes, reset values and shared types
// for the grid point and line plotter. No dependencies.

package gpl_pkg;

    localparam int COORD_W = 12;
    localparam int PIX_W   = 8;

    // opcodes
    localparam logic [1:0] OP_POINT = 2'd0;
    localparam logic [1:0] OP_LINE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic CFG_INCREMENT  = 1'b0;
    localparam logic CFG_LINE_VALUE = 1'b1;

    // direction flag codes
    localparam logic [1:0] DIR_IN  = 2'b00;
    localparam logic [1:0] DIR_POS = 2'b01;
    localparam logic [1:0] DIR_NEG = 2'b11;

    localparam logic [PIX_W-1:0] PIX_MAX      = 8'd255;
    localparam int               RST_INC_I    = 25;
    localparam logic [PIX_W-1:0] RST_INC      = 8'(RST_INC_I);
    localparam logic [PIX_W-1:0] RST_LINE_VAL = 8'd100;
    localparam logic [PIX_W-1:0] RST_THR      = 8'(RST_INC_I * (255 / RST_INC_I));

    // line stepper status toward the sequencer
    typedef struct packed {
        logic valid;
        logic last;
    } ln_stat_t;

endpackage

// ===== rtl/grid_point_and_line_plotter.sv =====
// grid_point_and_line_plotter: top level with sequencer, config registers,
// clearing pass and result register. Depends on gpl_pkg, gpl_thresh,
// gpl_line and gpl_grid.

// An 8-bit occupancy grid of GRID_WIDTH x GRID_HEIGHT pixels. After reset the
// block sweeps the store to zero, one pixel per cycle, over all
// GRID_WIDTH * GRID_HEIGHT pixels; s_ready stays low meanwhile.
// One item is worked at a time. A point or read goes from accept to a
// loaded result through a read of the store, then update or capture; a line
// is walked by the stepper, which visits one pixel per cycle
// through a read port and a write port of the store, and an item with an
// out-of-grid coordinate or an unused opcode goes straight to the result. A
// nonzero write of increment keeps s_ready low while the threshold divider runs. The next
// item is taken while a finished result still waits on m_ready.

module grid_point_and_line_plotter #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_op,
    input  logic signed [gpl_pkg::COORD_W-1:0]  s_ax,
    input  logic signed [gpl_pkg::COORD_W-1:0]  s_ay,
    input  logic signed [gpl_pkg::COORD_W-1:0]  s_bx,
    input  logic signed [gpl_pkg::COORD_W-1:0]  s_by,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_status,
    output logic signed [1:0]                   m_dir_x,
    output logic signed [1:0]                   m_dir_y,
    output logic [gpl_pkg::PIX_W-1:0]           m_pixel,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [gpl_pkg::PIX_W-1:0]           cfg_data
);

    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = gpl_pkg::COORD_W + 1;

    localparam logic signed [LW-1:0] LIM_X = LW'(GRID_WIDTH);
    localparam logic signed [LW-1:0] LIM_Y = LW'(GRID_HEIGHT);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ACC    = 7'b0000010,
        ST_PT_WR  = 7'b0000100,
        ST_RD_CAP = 7'b0001000,
        ST_LINE   = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    function automatic logic [1:0] dir_of(
        input logic signed [gpl_pkg::COORD_W-1:0] v,
        input logic signed [LW-1:0]               lim
    );
        logic signed [LW-1:0] ve;
        ve = $signed({v[gpl_pkg::COORD_W-1], v});
        if (v[gpl_pkg::COORD_W-1]) begin
            return gpl_pkg::DIR_NEG;
        end else if (ve >= lim) begin
            return gpl_pkg::DIR_POS;
        end
        return gpl_pkg::DIR_IN;
    endfunction

    function automatic logic [AW-1:0] addr_of(
        input logic [XW-1:0] x,
        input logic [YW-1:0] y
    );
        return AW'(y) * AW'(GRID_WIDTH) + AW'(x);
    endfunction

    state_t state_reg, state_next;

    // config and clearing
    logic [gpl_pkg::PIX_W-1:0] inc_reg;
    logic [gpl_pkg::PIX_W-1:0] lval_reg;
    logic                      clr_busy_reg;
    logic [AW-1:0]             clr_addr_reg;

    // item in progress
    logic [1:0]                op_reg;
    logic [XW-1:0]             x_reg;
    logic [YW-1:0]             y_reg;
    logic                      pend_status_reg;
    logic [1:0]                pend_dx_reg;
    logic [1:0]                pend_dy_reg;
    logic [gpl_pkg::PIX_W-1:0] pend_pix_reg;

    // line write-back stage
    logic                      p1_valid_reg;
    logic [AW-1:0]             p1_addr_reg;

    // result register
    logic                      m_valid_reg;
    logic                      mst_reg;
    logic [1:0]                mdx_reg;
    logic [1:0]                mdy_reg;
    logic [gpl_pkg::PIX_W-1:0] mpix_reg;

    logic                      s_acc;
    logic                      out_load;
    logic [1:0]                dxa;
    logic [1:0]                dya;
    logic [1:0]                dxb;
    logic [1:0]                dyb;
    logic                      a_in;
    logic                      b_in;
    logic                      acc_status;
    logic [1:0]                acc_dx;
    logic [1:0]                acc_dy;
    logic                      ln_start;

    logic                      thr_busy;
    logic [gpl_pkg::PIX_W-1:0] thr;
    logic [XW-1:0]             ln_x;
    logic [YW-1:0]             ln_y;
    gpl_pkg::ln_stat_t         ln_stat;

    logic [XW-1:0]             cur_x;
    logic [YW-1:0]             cur_y;
    logic [AW-1:0]             cur_addr;
    logic [gpl_pkg::PIX_W-1:0] rd_data;
    logic [gpl_pkg::PIX_W:0]   pt_sum;
    logic [gpl_pkg::PIX_W-1:0] pt_val;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [gpl_pkg::PIX_W-1:0] mem_wdata;

    assign s_ready  = (state_reg == ST_IDLE) && !clr_busy_reg && !thr_busy;
    assign s_acc    = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // range flags and result fields known at accept time
    always_comb begin
        dxa        = dir_of(s_ax, LIM_X);
        dya        = dir_of(s_ay, LIM_Y);
        dxb        = dir_of(s_bx, LIM_X);
        dyb        = dir_of(s_by, LIM_Y);
        a_in       = (dxa == gpl_pkg::DIR_IN) && (dya == gpl_pkg::DIR_IN);
        b_in       = (dxb == gpl_pkg::DIR_IN) && (dyb == gpl_pkg::DIR_IN);
        acc_status = 1'b0;
        acc_dx     = gpl_pkg::DIR_IN;
        acc_dy     = gpl_pkg::DIR_IN;
        case (s_op)
            gpl_pkg::OP_POINT, gpl_pkg::OP_READ: begin
                acc_status = !a_in;
                acc_dx     = dxa;
                acc_dy     = dya;
            end
            gpl_pkg::OP_LINE: begin
                // start flags win when the start is outside
                acc_status = !(a_in && b_in);
                acc_dx     = a_in ? dxb : dxa;
                acc_dy     = a_in ? dyb : dya;
            end
            default: begin
            end
        endcase
        ln_start = s_acc && (s_op == gpl_pkg::OP_LINE) && a_in && b_in;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (acc_status) begin
                        state_next = ST_DONE;
                    end else if (s_op == gpl_pkg::OP_POINT || s_op == gpl_pkg::OP_READ) begin
                        state_next = ST_ACC;
                    end else if (s_op == gpl_pkg::OP_LINE) begin
                        state_next = ST_LINE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ACC: begin
                state_next = (op_reg == gpl_pkg::OP_READ) ? ST_RD_CAP : ST_PT_WR;
            end
            ST_PT_WR: begin
                state_next = ST_DONE;
            end
            ST_RD_CAP: begin
                state_next = ST_DONE;
            end
            ST_LINE: begin
                if (ln_stat.last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            inc_reg      <= gpl_pkg::RST_INC;
            lval_reg     <= gpl_pkg::RST_LINE_VAL;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en && cfg_index == gpl_pkg::CFG_INCREMENT) begin
                inc_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == gpl_pkg::CFG_LINE_VALUE) begin
                lval_reg <= cfg_data;
            end
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            p1_valid_reg <= (state_reg == ST_LINE) && ln_stat.valid;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg          <= s_op;
            x_reg           <= s_ax[XW-1:0];
            y_reg           <= s_ay[YW-1:0];
            pend_status_reg <= acc_status;
            pend_dx_reg     <= acc_dx;
            pend_dy_reg     <= acc_dy;
            pend_pix_reg    <= '0;
        end else if (state_reg == ST_RD_CAP) begin
            pend_pix_reg <= rd_data;
        end
        p1_addr_reg <= cur_addr;
        if (out_load) begin
            mst_reg  <= pend_status_reg;
            mdx_reg  <= pend_dx_reg;
            mdy_reg  <= pend_dy_reg;
            mpix_reg <= pend_pix_reg;
        end
    end

    // store address and write selection
    always_comb begin
        cur_x    = (state_reg == ST_LINE) ? ln_x : x_reg;
        cur_y    = (state_reg == ST_LINE) ? ln_y : y_reg;
        cur_addr = addr_of(cur_x, cur_y);
        pt_sum   = {1'b0, rd_data} + {1'b0, inc_reg};
        pt_val   = (rd_data < thr) ? pt_sum[gpl_pkg::PIX_W-1:0] : gpl_pkg::PIX_MAX;
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = pt_val;
        if (clr_busy_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if (state_reg == ST_PT_WR) begin
            mem_we = 1'b1;
        end else if (p1_valid_reg && rd_data == '0) begin
            // line pixels only fill empty cells
            mem_we    = 1'b1;
            mem_waddr = p1_addr_reg;
            mem_wdata = lval_reg;
        end
    end

    gpl_thresh u_thresh (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (cfg_wr_en && cfg_index == gpl_pkg::CFG_INCREMENT),
        .divisor (cfg_data),
        .busy    (thr_busy),
        .thresh  (thr)
    );

    gpl_line #(
        .XW (XW),
        .YW (YW)
    ) u_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ln_start),
        .ax      (s_ax[XW-1:0]),
        .ay      (s_ay[YW-1:0]),
        .bx      (s_bx[XW-1:0]),
        .by      (s_by[YW-1:0]),
        .pix_x   (ln_x),
        .pix_y   (ln_y),
        .stat    (ln_stat)
    );

    gpl_grid #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cur_addr),
        .rdata (rd_data)
    );

    assign m_valid  = m_valid_reg;
    assign m_status = mst_reg;
    assign m_dir_x  = $signed(mdx_reg);
    assign m_dir_y  = $signed(mdy_reg);
    assign m_pixel  = mpix_reg;

endmodule

// ===== rtl/gpl_thresh.sv =====
// gpl_thresh: saturation threshold unit, increment * floor(255 / increment),
// found as 255 minus the remainder of a bit-serial restoring division.
// Depends on gpl_pkg.

module gpl_thresh (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  logic [gpl_pkg::PIX_W-1:0] divisor,
    output logic                      busy,
    output logic [gpl_pkg::PIX_W-1:0] thresh
);

    logic                      busy_reg;
    logic [2:0]                cnt_reg;
    logic [gpl_pkg::PIX_W-1:0] div_reg;
    logic [gpl_pkg::PIX_W-1:0] rem_reg;
    logic [gpl_pkg::PIX_W-1:0] rem_next;
    logic [gpl_pkg::PIX_W-1:0] thr_reg;
    logic [gpl_pkg::PIX_W:0]   trial;

    // dividend is all ones, so every step shifts in a one
    always_comb begin
        trial = {rem_reg, 1'b1};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = gpl_pkg::PIX_W'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[gpl_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            thr_reg  <= gpl_pkg::RST_THR;
        end else if (load) begin
            if (divisor == '0) begin
                busy_reg <= 1'b0;
                thr_reg  <= '0;
            end else begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_reg <= 1'b0;
                thr_reg  <= gpl_pkg::PIX_MAX - rem_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
        end
    end

    assign busy   = busy_reg;
    assign thresh = thr_reg;

endmodule

// ===== rtl/gpl_line.sv =====
// gpl_line: Bresenham line stepper, one pixel per cycle after a setup step.
// Depends on gpl_pkg.

module gpl_line #(
    parameter int XW = 8,
    parameter int YW = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [XW-1:0]     ax,
    input  logic [YW-1:0]     ay,
    input  logic [XW-1:0]     bx,
    input  logic [YW-1:0]     by,
    output logic [XW-1:0]     pix_x,
    output logic [YW-1:0]     pix_y,
    output gpl_pkg::ln_stat_t stat
);

    localparam int CW = (XW > YW) ? XW : YW;
    localparam int EW = CW + 3;

    typedef enum logic [2:0] {
        LN_IDLE  = 3'b001,
        LN_SETUP = 3'b010,
        LN_STEP  = 3'b100
    } ln_state_t;

    ln_state_t state_reg, state_next;

    logic [XW-1:0]        x_reg;
    logic [YW-1:0]        y_reg;
    logic [CW-1:0]        dx_reg;
    logic [CW-1:0]        dy_reg;
    logic                 sx_reg;
    logic                 sy_reg;
    logic                 major_x_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [EW-1:0] err_reg;
    logic signed [EW-1:0] inc_pos_reg;
    logic signed [EW-1:0] inc_neg_reg;

    logic [XW-1:0]        dx_in;
    logic [YW-1:0]        dy_in;
    logic                 major_x;
    logic [CW-1:0]        maj;
    logic [CW-1:0]        mnr;
    logic signed [EW-1:0] maj1;
    logic signed [EW-1:0] maj2;
    logic signed [EW-1:0] mnr2;
    logic                 err_ge;
    logic [XW-1:0]        x_step;
    logic [YW-1:0]        y_step;

    always_comb begin
        dx_in   = (bx > ax) ? bx - ax : ax - bx;
        dy_in   = (by > ay) ? by - ay : ay - by;
        major_x = (dx_reg >= dy_reg);
        maj     = major_x ? dx_reg : dy_reg;
        mnr     = major_x ? dy_reg : dx_reg;
        maj1    = $signed(EW'(maj));
        maj2    = $signed(EW'({maj, 1'b0}));
        mnr2    = $signed(EW'({mnr, 1'b0}));
        err_ge  = !err_reg[EW-1];
        x_step  = sx_reg ? x_reg + XW'(1) : x_reg - XW'(1);
        y_step  = sy_reg ? y_reg + YW'(1) : y_reg - YW'(1);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            LN_IDLE: begin
                if (start) begin
                    state_next = LN_SETUP;
                end
            end
            LN_SETUP: begin
                state_next = LN_STEP;
            end
            LN_STEP: begin
                if (cnt_reg == '0) begin
                    state_next = LN_IDLE;
                end
            end
            default: begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LN_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            LN_IDLE: begin
                if (start) begin
                    x_reg  <= ax;
                    y_reg  <= ay;
                    dx_reg <= CW'(dx_in);
                    dy_reg <= CW'(dy_in);
                    sx_reg <= (bx > ax);
                    sy_reg <= (by > ay);
                end
            end
            LN_SETUP: begin
                major_x_reg <= major_x;
                cnt_reg     <= maj;
                err_reg     <= mnr2 - maj1;
                inc_pos_reg <= mnr2 - maj2;
                inc_neg_reg <= mnr2;
            end
            LN_STEP: begin
                // major axis always moves, minor axis on non-negative error
                if (major_x_reg) begin
                    x_reg <= x_step;
                    if (err_ge) begin
                        y_reg <= y_step;
                    end
                end else begin
                    y_reg <= y_step;
                    if (err_ge) begin
                        x_reg <= x_step;
                    end
                end
                err_reg <= err_reg + (err_ge ? inc_pos_reg : inc_neg_reg);
                cnt_reg <= cnt_reg - CW'(1);
            end
            default: begin
            end
        endcase
    end

    assign pix_x      = x_reg;
    assign pix_y      = y_reg;
    assign stat.valid = (state_reg == LN_STEP);
    assign stat.last  = (state_reg == LN_STEP) && (cnt_reg == '0);

endmodule

// ===== rtl/gpl_grid.sv =====
// gpl_grid: pixel store, one write port and one registered read port.
// No package dependency.

module gpl_grid #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== verif/grid_point_and_line_plotter_tb.sv =====
// grid_point_and_line_plotter_tb: self-checking bench for the grid plotter.
// Needs gpl_pkg and grid_point_and_line_plotter; keeps its own image of the
// grid and checks every result beat against it.

module grid_point_and_line_plotter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W          = 256;
    localparam int GRID_H          = 256;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int HOT_BASE        = 40;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int N_PHASES        = 7;
    localparam int SETTLE_CYCLES   = GRID_W + 16;
    localparam int WDOG_LIMIT      = 3 * GRID_W * GRID_H;
    localparam int MAX_REPORTS     = 40;

    typedef struct {
        logic [1:0]                         op;
        logic signed [gpl_pkg::COORD_W-1:0] ax;
        logic signed [gpl_pkg::COORD_W-1:0] ay;
        logic signed [gpl_pkg::COORD_W-1:0] bx;
        logic signed [gpl_pkg::COORD_W-1:0] by;
    } plot_cmd_t;

    typedef struct {
        logic                      status;
        logic [1:0]                dir_x;
        logic [1:0]                dir_y;
        logic [gpl_pkg::PIX_W-1:0] pixel;
    } plot_resp_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [1:0]                         s_op    = '0;
    logic signed [gpl_pkg::COORD_W-1:0] s_ax    = '0;
    logic signed [gpl_pkg::COORD_W-1:0] s_ay    = '0;
    logic signed [gpl_pkg::COORD_W-1:0] s_bx    = '0;
    logic signed [gpl_pkg::COORD_W-1:0] s_by    = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic                               m_status;
    logic signed [1:0]                  m_dir_x;
    logic signed [1:0]                  m_dir_y;
    logic [gpl_pkg::PIX_W-1:0]          m_pixel;
    logic                               cfg_wr_en = 1'b0;
    logic                               cfg_index = 1'b0;
    logic [gpl_pkg::PIX_W-1:0]          cfg_data  = '0;

    grid_point_and_line_plotter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_ax      (s_ax),
        .s_ay      (s_ay),
        .s_bx      (s_bx),
        .s_by      (s_by),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_dir_x   (m_dir_x),
        .m_dir_y   (m_dir_y),
        .m_pixel   (m_pixel),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // grid image and register copies
    logic [gpl_pkg::PIX_W-1:0] grid_img [GRID_W*GRID_H];
    logic [gpl_pkg::PIX_W-1:0] inc_reg   = gpl_pkg::RST_INC;
    logic [gpl_pkg::PIX_W-1:0] line_reg  = gpl_pkg::RST_LINE_VAL;
    logic [gpl_pkg::PIX_W-1:0] sat_level = gpl_pkg::RST_THR;

    plot_cmd_t  cmd_q[$];
    plot_resp_t due_results[$];

    bit in_beat;
    bit out_beat;
    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;
    int src_gap     = 0;
    int snk_stall   = 0;
    int idle_cycles = 0;
    int errors      = 0;
    int n_checked   = 0;
    int n_point     = 0;
    int n_line      = 0;
    int n_read      = 0;
    int n_unused    = 0;
    int n_offgrid   = 0;
    int n_settings  = 1;

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic logic [gpl_pkg::PIX_W-1:0] sat_for(logic [gpl_pkg::PIX_W-1:0] inc);
        if (inc == '0)
            return '0;
        return gpl_pkg::PIX_W'(int'(inc) * (255 / int'(inc)));
    endfunction

    function automatic logic [1:0] off_dir(int v, int lim);
        if (v < 0)
            return gpl_pkg::DIR_NEG;
        if (v >= lim)
            return gpl_pkg::DIR_POS;
        return gpl_pkg::DIR_IN;
    endfunction

    task automatic plot_if_empty(int x, int y);
        int idx;
        if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H)
            return;
        idx = y * GRID_W + x;
        if (grid_img[idx] == '0)
            grid_img[idx] = line_reg;
    endtask

    task automatic trace_line(int x0, int y0, int x1, int y1);
        int dx, dy, sx, sy, x, y, err, n;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        sx = (x1 > x0) ? 1 : -1;
        sy = (y1 > y0) ? 1 : -1;
        x  = x0;
        y  = y0;
        if (dx >= dy) begin
            err = 2 * dy - dx;
            for (n = 0; n <= dx; n++) begin
                plot_if_empty(x, y);
                if (err >= 0) begin
                    y   += sy;
                    err -= 2 * dx;
                end
                err += 2 * dy;
                x   += sx;
            end
        end else begin
            err = 2 * dx - dy;
            for (n = 0; n <= dy; n++) begin
                plot_if_empty(x, y);
                if (err >= 0) begin
                    x   += sx;
                    err -= 2 * dy;
                end
                err += 2 * dx;
                y   += sy;
            end
        end
    endtask

    // updates the grid image and returns the result the block owes for c
    task automatic apply_plot_cmd(input plot_cmd_t c, output plot_resp_t r);
        int x0, y0, x1, y1, idx;
        logic [1:0] fx, fy;
        x0 = int'(c.ax);
        y0 = int'(c.ay);
        x1 = int'(c.bx);
        y1 = int'(c.by);
        r.status = 1'b0;
        r.dir_x  = gpl_pkg::DIR_IN;
        r.dir_y  = gpl_pkg::DIR_IN;
        r.pixel  = '0;
        case (c.op)
            gpl_pkg::OP_POINT, gpl_pkg::OP_READ: begin
                fx = off_dir(x0, GRID_W);
                fy = off_dir(y0, GRID_H);
                if (fx != gpl_pkg::DIR_IN || fy != gpl_pkg::DIR_IN) begin
                    r.status = 1'b1;
                    r.dir_x  = fx;
                    r.dir_y  = fy;
                end else begin
                    idx = y0 * GRID_W + x0;
                    if (c.op == gpl_pkg::OP_READ)
                        r.pixel = grid_img[idx];
                    else if (grid_img[idx] < sat_level)
                        grid_img[idx] = grid_img[idx] + inc_reg;
                    else
                        grid_img[idx] = gpl_pkg::PIX_MAX;
                end
            end
            gpl_pkg::OP_LINE: begin
                // start flags win; end flags only matter when start is inside
                fx = off_dir(x0, GRID_W);
                fy = off_dir(y0, GRID_H);
                if (fx == gpl_pkg::DIR_IN && fy == gpl_pkg::DIR_IN) begin
                    fx = off_dir(x1, GRID_W);
                    fy = off_dir(y1, GRID_H);
                end
                if (fx != gpl_pkg::DIR_IN || fy != gpl_pkg::DIR_IN) begin
                    r.status = 1'b1;
                    r.dir_x  = fx;
                    r.dir_y  = fy;
                end else begin
                    trace_line(x0, y0, x1, y1);
                end
            end
            default: ;
        endcase
    endtask

    // input side: one beat at a time from cmd_q, random gaps after beats
    always @(negedge aclk) begin
        plot_cmd_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_beat) begin
            if (in_beat && src_idle_en && $urandom_range(0, 5) == 0)
                src_gap = $urandom_range(1, 18);
            if (src_gap > 0 || cmd_q.size() == 0) begin
                if (src_gap > 0)
                    src_gap--;
                s_valid <= 1'b0;
            end else begin
                cur = cmd_q.pop_front();
                s_op    <= cur.op;
                s_ax    <= cur.ax;
                s_ay    <= cur.ay;
                s_bx    <= cur.bx;
                s_by    <= cur.by;
                s_valid <= 1'b1;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (snk_stall > 0) begin
            snk_stall--;
            m_ready <= 1'b0;
        end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
            snk_stall = $urandom_range(1, 18) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // sampling, prediction, checking and watchdog
    always @(posedge aclk) begin
        plot_cmd_t  cmd;
        plot_resp_t pred;
        plot_resp_t oldest;
        in_beat  = aresetn && s_valid && s_ready;
        out_beat = aresetn && m_valid && m_ready;

        if (aresetn && cfg_wr_en) begin
            if (cfg_index == gpl_pkg::CFG_INCREMENT) begin
                inc_reg   = cfg_data;
                sat_level = sat_for(cfg_data);
            end else begin
                line_reg = cfg_data;
            end
        end

        if (in_beat) begin
            cmd.op = s_op;
            cmd.ax = s_ax;
            cmd.ay = s_ay;
            cmd.bx = s_bx;
            cmd.by = s_by;
            apply_plot_cmd(cmd, pred);
            due_results = {due_results, pred};
            case (s_op)
                gpl_pkg::OP_POINT: n_point++;
                gpl_pkg::OP_LINE:  n_line++;
                gpl_pkg::OP_READ:  n_read++;
                default:           n_unused++;
            endcase
            if (pred.status)
                n_offgrid++;
        end

        if (out_beat) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result beat, status", m_status, 0);
            end else begin
                oldest = due_results.pop_front();
                n_checked++;
                if (m_status !== oldest.status)
                    report_mismatch("status", m_status, oldest.status);
                if (m_dir_x !== oldest.dir_x)
                    report_mismatch("dir_x", int'(m_dir_x), int'($signed(oldest.dir_x)));
                if (m_dir_y !== oldest.dir_y)
                    report_mismatch("dir_y", int'(m_dir_y), int'($signed(oldest.dir_y)));
                if (m_pixel !== oldest.pixel)
                    report_mismatch("pixel", m_pixel, oldest.pixel);
            end
        end

        if (in_beat || out_beat || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [gpl_pkg::COORD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return gpl_pkg::COORD_W'(HOT_BASE + $urandom_range(0, 7));
        if (r < 75)
            return gpl_pkg::COORD_W'($urandom_range(0, 255));
        if (r < 88) begin
            case ($urandom_range(0, 5))
                0:       return -12'sd1;
                1:       return 12'sd0;
                2:       return 12'sd255;
                3:       return 12'sd256;
                4:       return gpl_pkg::COORD_W'(-2048);
                default: return 12'sd2047;
            endcase
        end
        return gpl_pkg::COORD_W'($urandom);
    endfunction

    // mostly short lines near the start, a few long or wild ones
    function automatic logic signed [gpl_pkg::COORD_W-1:0] line_end(
        logic signed [gpl_pkg::COORD_W-1:0] from
    );
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return gpl_pkg::COORD_W'(int'(from) + $urandom_range(0, 24) - 12);
        if (r < 85)
            return gpl_pkg::COORD_W'($urandom_range(0, 255));
        return pick_coord();
    endfunction

    task automatic add_cmd(logic [1:0] op, int ax, int ay, int bx, int by);
        plot_cmd_t c;
        c.op = op;
        c.ax = gpl_pkg::COORD_W'(ax);
        c.ay = gpl_pkg::COORD_W'(ay);
        c.bx = gpl_pkg::COORD_W'(bx);
        c.by = gpl_pkg::COORD_W'(by);
        cmd_q = {cmd_q, c};
    endtask

    task automatic queue_random(int n);
        plot_cmd_t c;
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                c.op = gpl_pkg::OP_POINT;
            else if (r < 70)
                c.op = gpl_pkg::OP_READ;
            else if (r < 95)
                c.op = gpl_pkg::OP_LINE;
            else
                c.op = OP_NONE;
            c.ax = pick_coord();
            c.ay = pick_coord();
            if (c.op == gpl_pkg::OP_LINE) begin
                c.bx = line_end(c.ax);
                c.by = line_end(c.ay);
            end else begin
                c.bx = gpl_pkg::COORD_W'($urandom);
                c.by = gpl_pkg::COORD_W'($urandom);
            end
            cmd_q = {cmd_q, c};
        end
    endtask

    // wait for every beat to be sent and answered, then let the block settle
    task automatic drain();
        while (cmd_q.size() != 0 || s_valid || due_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(logic [gpl_pkg::PIX_W-1:0] inc, logic [gpl_pkg::PIX_W-1:0] lv);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= gpl_pkg::CFG_INCREMENT;
        cfg_data  <= inc;
        @(negedge aclk);
        cfg_index <= gpl_pkg::CFG_LINE_VALUE;
        cfg_data  <= lv;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int ph;
        foreach (grid_img[i])
            grid_img[i] = '0;

        // directed: corners, off-grid in every direction, line shapes
        add_cmd(gpl_pkg::OP_READ,  0, 0, 0, 0);
        add_cmd(gpl_pkg::OP_POINT, 0, 0, 2047, -2048);
        add_cmd(gpl_pkg::OP_READ,  0, 0, -1, 2047);
        add_cmd(gpl_pkg::OP_POINT, 255, 255, 0, 0);
        add_cmd(gpl_pkg::OP_POINT, 255, 255, 0, 0);
        add_cmd(gpl_pkg::OP_READ,  255, 255, 0, 0);
        add_cmd(gpl_pkg::OP_POINT, -1, 0, 0, 0);
        add_cmd(gpl_pkg::OP_POINT, 256, 5, 0, 0);
        add_cmd(gpl_pkg::OP_READ,  3, -2048, 0, 0);
        add_cmd(gpl_pkg::OP_READ,  2047, 2047, 0, 0);
        add_cmd(gpl_pkg::OP_READ,  -2048, 256, 0, 0);
        add_cmd(gpl_pkg::OP_LINE,  0, 0, 255, 0);
        add_cmd(gpl_pkg::OP_LINE,  10, 10, 13, 20);
        add_cmd(gpl_pkg::OP_LINE,  20, 5, 5, 3);
        add_cmd(gpl_pkg::OP_LINE,  100, 100, 100, 100);
        add_cmd(gpl_pkg::OP_LINE,  -5, 3, 300, 3);
        add_cmd(gpl_pkg::OP_LINE,  5, 5, 5, 300);
        add_cmd(gpl_pkg::OP_LINE,  300, -1, -4, -7);
        add_cmd(gpl_pkg::OP_READ,  5, 0, 0, 0);
        add_cmd(gpl_pkg::OP_READ,  0, 0, 0, 0);
        add_cmd(gpl_pkg::OP_READ,  100, 100, 0, 0);
        add_cmd(OP_NONE,           -1366, 1365, 2047, -2048);
        add_cmd(gpl_pkg::OP_LINE,  255, 255, 0, 0);
        add_cmd(gpl_pkg::OP_READ,  128, 128, 0, 0);
        add_cmd(gpl_pkg::OP_POINT, 128, 128, 0, 0);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        drain();

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                1: set_regs(8'd1,   8'd255);
                2: set_regs(8'd255, 8'd1);
                3: set_regs(8'd0,   8'd37);
                4: set_regs(8'd200, 8'd128);
                5: set_regs(8'd7,   8'd3);
                6: set_regs(8'd128, 8'd255);
                default: ;
            endcase
            src_idle_en = (ph != 4 && ph != N_PHASES - 1);
            snk_idle_en = (ph != 3 && ph != N_PHASES - 1);
            queue_random(ITEMS_PER_PHASE);
            drain();
        end

        $display("covered %0d points, %0d lines, %0d reads, %0d unused opcodes (%0d off-grid)",
                 n_point, n_line, n_read, n_unused, n_offgrid);
        $display("%0d results checked over %0d register settings, %0d mismatches",
                 n_checked, n_settings, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
